FILE: hw/rtl/tlvx_pkg.sv
package tlvx_pkg;

    // frame format limits
    localparam int MaxPayloadBytes = 4;
    localparam int PayloadSlots    = 4;
    localparam int SlotIdxW        = 2;
    localparam int LenW            = 3;
    localparam int CountW          = 3;

    localparam logic [7:0] MaxTypeReset = 8'd8;

    // one recognised frame
    typedef struct packed {
        logic [7:0]                      ftype;
        logic [LenW-1:0]                 length;
        logic [PayloadSlots-1:0][7:0]    payload;
    } frame_t;

    // parser status towards the top level
    typedef struct packed {
        logic in_check;
        logic hit;
    } parse_status_t;

endpackage

FILE: hw/rtl/tlvx_input_stage.sv
module tlvx_input_stage
    import tlvx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       consume,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // slot frees up in the same cycle its item is consumed
    assign in_ready   = !valid_reg || consume;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !consume);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

FILE: hw/rtl/tlvx_parser.sv
module tlvx_parser
    import tlvx_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    rx_byte,
    input  logic [7:0]    max_command_type,
    output frame_t        frame,
    output parse_status_t status
);

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LENGTH,
        PH_DATA,
        PH_CHECK
    } phase_t;

    phase_t                       phase_reg;
    phase_t                       phase_next;
    logic [7:0]                   held_type_reg;
    logic [7:0]                   held_type_next;
    logic [LenW-1:0]              held_length_reg;
    logic [LenW-1:0]              held_length_next;
    logic [CountW-1:0]            count_reg;
    logic [CountW-1:0]            count_next;
    logic [PayloadSlots-1:0][7:0] payload_reg;
    logic [PayloadSlots-1:0][7:0] payload_next;
    logic [7:0]                   xor_reg;
    logic [7:0]                   xor_next;
    logic                         match;

    always_comb
    begin
        phase_next       = phase_reg;
        held_type_next   = held_type_reg;
        held_length_next = held_length_reg;
        count_next       = count_reg;
        payload_next     = payload_reg;
        xor_next         = xor_reg;
        match            = 1'b0;

        case (phase_reg)
            PH_TYPE:
            begin
                if (rx_byte <= max_command_type)
                begin
                    held_type_next = rx_byte;
                    xor_next       = rx_byte;
                    phase_next     = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                if (rx_byte == 8'd0 || rx_byte > 8'(MaxPayloadBytes))
                begin
                    phase_next = PH_TYPE;
                end
                else
                begin
                    held_length_next = rx_byte[LenW-1:0];
                    count_next       = '0;
                    xor_next         = xor_reg ^ rx_byte;
                    phase_next       = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (count_reg < held_length_reg)
                begin
                    // bytes past the stored slots only enter the checksum
                    if (count_reg < CountW'(PayloadSlots))
                    begin
                        payload_next[count_reg[SlotIdxW-1:0]] = rx_byte;
                    end
                    xor_next   = xor_reg ^ rx_byte;
                    count_next = count_reg + 1'b1;
                end
                if (count_next >= held_length_reg)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                phase_next = PH_TYPE;
                match      = (rx_byte == xor_reg);
            end
            default:
            begin
                phase_next = PH_TYPE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_TYPE;
            held_type_reg   <= '0;
            held_length_reg <= '0;
            count_reg       <= '0;
            payload_reg     <= '0;
            xor_reg         <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            held_type_reg   <= held_type_next;
            held_length_reg <= held_length_next;
            count_reg       <= count_next;
            payload_reg     <= payload_next;
            xor_reg         <= xor_next;
        end
    end

    assign frame.ftype   = held_type_reg;
    assign frame.length  = held_length_reg;
    assign frame.payload = payload_reg;

    assign status.in_check = (phase_reg == PH_CHECK);
    assign status.hit      = step && match;

endmodule

FILE: hw/rtl/tlvx_output_stage.sv
module tlvx_output_stage
    import tlvx_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  frame_t                      frame,
    output logic                        free,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  frame_type,
    output logic [LenW-1:0]             frame_length,
    output logic [8*PayloadSlots-1:0]   frame_payload
);

    logic   valid_reg;
    logic   valid_next;
    frame_t frame_reg;

    // can take a new frame when empty or when the held one leaves now
    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= frame;
        end
    end

    assign out_valid     = valid_reg;
    assign frame_type    = frame_reg.ftype;
    assign frame_length  = frame_reg.length;
    assign frame_payload = frame_reg.payload;

endmodule

FILE: hw/rtl/tlv_frame_xor_receiver.sv
// timing: a byte is registered on acceptance and parsed once the result register has
//   room; a matching checksum byte loads its frame into the result register as it is
//   parsed, so the frame passes the input register and then the result register
// throughput: one byte per cycle while the result side keeps out_ready high
// reset (rst_n, asynchronous, active low): parser waits for a type byte, held fields,
//   payload and checksum clear to zero, max_command_type returns to 8, no item held
module tlv_frame_xor_receiver
    import tlvx_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                rx_byte,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                frame_type,
    output logic [LenW-1:0]           frame_length,
    output logic [8*PayloadSlots-1:0] frame_payload,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [7:0]                max_command_type
);

    logic          byte_valid;
    logic [7:0]    byte_held;
    logic          out_free;
    logic          step;
    logic [7:0]    max_type_reg;
    frame_t        frame;
    parse_status_t status;

    // configuration register, always ready to take a write
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_type_reg <= MaxTypeReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_type_reg <= max_command_type;
        end
    end

    // input register: holds one received byte, refills while it drains
    tlvx_input_stage u_input_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .consume    (step),
        .held_valid (byte_valid),
        .held_byte  (byte_held)
    );

    // a byte is parsed only when the result register has room, so a
    // matching checksum byte never finds the output slot occupied
    assign step = byte_valid && out_free;

    // frame state machine with running xor and payload bytes
    tlvx_parser u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .rx_byte          (byte_held),
        .max_command_type (max_type_reg),
        .frame            (frame),
        .status           (status)
    );

    // result register towards the consumer
    tlvx_output_stage u_output_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (status.hit),
        .frame         (frame),
        .free          (out_free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_type    (frame_type),
        .frame_length  (frame_length),
        .frame_payload (frame_payload)
    );

    // a new result only ever comes from a checksum byte
    a_result_from_check: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(status.in_check)
    ) else $error("result appeared without a checksum byte");

    // every delivered frame carries a legal length
    a_length_legal: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_length != '0 && frame_length <= LenW'(MaxPayloadBytes))
    ) else $error("frame length out of range");

    // a held byte that is not parsed must not be lost
    a_byte_kept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (byte_valid && !step) |=> byte_valid
    ) else $error("held input byte dropped");

    // no frame is loaded while the result register is full and stalled
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !status.hit
    ) else $error("result register overwritten");

endmodule
